>>> design/assert_macros.svh
// Assertion macros shared by the sorted insertion core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising clock edge outside reset.
`define KNNSI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("knnsi: property violated");

// Check that a condition never occurs outside reset.
`define KNNSI_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("knnsi: forbidden condition seen");

`else

`define KNNSI_ASSERT(lbl, clk, rstn, prop)
`define KNNSI_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> design/knnsi_pkg.sv
// Shared constants and controller/datapath interface types of the sorted insertion core.
`default_nettype none

package knnsi_pkg;

  // Fixed field widths
  localparam int MASS_W     = 32;
  localparam int INDEX_W    = 24;
  localparam int DIST_OUT_W = 50;
  localparam int COUNT_W    = 7;
  localparam int RANK_W     = 6;
  localparam int KNB_W      = 7;
  localparam int RADIUS_W   = 50;
  localparam int CFG_DATA_W = 50;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBORS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS2   = 3'd5;

  // Register reset values
  localparam logic [KNB_W-1:0]    KNB_RST     = 7'd64;
  localparam logic [RADIUS_W-1:0] RADIUS2_RST = 50'd703687441777;

  // Input action codes
  localparam logic ACT_CANDIDATE = 1'b0;
  localparam logic ACT_DRAIN     = 1'b1;

  // Result kind codes
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;         // capture candidate, form axis differences
    logic square;       // register the three axis squares
    logic sum;          // register the squared distance
    logic clamp;        // cut fill to k, fetch last held entry
    logic decide;       // evaluate acceptance, set insert pointer
    logic shift;        // move one entry up or place the candidate
    logic stat_load;    // load a status result into the output register
    logic drain_start;  // fetch last held entry for a drain
    logic drain_kth;    // capture k-th distance, fetch first entry
    logic drain_load;   // load one drained entry into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ok;           // candidate goes into the list
    logic stop;         // insert pointer reached its slot
    logic drain_last;   // current drained entry is the final one
    logic out_free;     // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

>>> design/knn_sorted_insert_core.sv
// Top level of the k-nearest sorted insertion core: configuration registers and unit wiring.
//
// Usage: write the query point, k, limit enable and squared radius through the cfg_ port
// (cfg_we, cfg_index, cfg_data) while the core is idle. Offer candidates on the in_ channel
// with in_action = 0; each returns one status result (accepted, count, k-th squared
// distance) on the out_ channel. in_action = 1 drains the list nearest first, one result
// per entry with out_last on the final one, and clears it; an empty list gives one marker.
// Both channels transfer when valid is high and stall is low.
// Sequence: a candidate is taken, its axis squares and squared distance registered, the
// fill cut to k and acceptance decided; an accepted one then moves one entry per cycle
// through the list memory's separate read and write ports, farther entries up one slot,
// and places itself. Its status result is then loaded into the output register once that
// register is free. A drain fetches the last held entry and the k-th distance, then loads
// one result per cycle through the memory read port while out_ does not stall.
// Reset (rst_n low, synchronous) empties the list, drops any result in the output register
// and restores the register defaults. A stall on out_ holds the result and the core waits
// in its output step; the next input transfer is still taken while a result waits.
`default_nettype none

module knn_sorted_insert_core #(
  parameter int K_MAX      = 64,
  parameter int COORD_BITS = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // configuration write port
  input  wire logic                                   cfg_we,
  input  wire logic [knnsi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [knnsi_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_action,
  input  wire logic [COORD_BITS-1:0]                  in_cand_x,
  input  wire logic [COORD_BITS-1:0]                  in_cand_y,
  input  wire logic [COORD_BITS-1:0]                  in_cand_z,
  input  wire logic [knnsi_pkg::MASS_W-1:0]           in_cand_mass,
  input  wire logic [knnsi_pkg::INDEX_W-1:0]          in_cand_index,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_kind,
  output logic                                        out_accepted,
  output logic [knnsi_pkg::COUNT_W-1:0]               out_count,
  output logic [knnsi_pkg::DIST_OUT_W-1:0]            out_kth_dist2,
  output logic [knnsi_pkg::RANK_W-1:0]                out_rank,
  output logic [knnsi_pkg::INDEX_W-1:0]               out_entry_index,
  output logic [knnsi_pkg::DIST_OUT_W-1:0]            out_entry_dist2,
  output logic [knnsi_pkg::MASS_W-1:0]                out_entry_mass,
  output logic                                        out_last
);

  localparam int CNTW = $clog2(K_MAX + 1);
  localparam int KW   = (CNTW > knnsi_pkg::KNB_W) ? CNTW : knnsi_pkg::KNB_W;
  localparam logic [KW-1:0] KMAX_W = KW'(K_MAX);

  // Configuration registers
  logic [COORD_BITS-1:0]               query_x_r, query_y_r, query_z_r;
  logic [knnsi_pkg::KNB_W-1:0]         knb_r;
  logic                                limit_en_r;
  logic [knnsi_pkg::RADIUS_W-1:0]      radius2_r;

  logic [KW-1:0]   knb_w;
  logic [CNTW-1:0] keff;

  knnsi_pkg::cmd_t cmd;
  knnsi_pkg::sts_t sts;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r  <= '0;
      query_y_r  <= '0;
      query_z_r  <= '0;
      knb_r      <= knnsi_pkg::KNB_RST;
      limit_en_r <= 1'b0;
      radius2_r  <= knnsi_pkg::RADIUS2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        knnsi_pkg::CFG_QUERY_X:   query_x_r  <= cfg_data[COORD_BITS-1:0];
        knnsi_pkg::CFG_QUERY_Y:   query_y_r  <= cfg_data[COORD_BITS-1:0];
        knnsi_pkg::CFG_QUERY_Z:   query_z_r  <= cfg_data[COORD_BITS-1:0];
        knnsi_pkg::CFG_NEIGHBORS: knb_r      <= cfg_data[knnsi_pkg::KNB_W-1:0];
        knnsi_pkg::CFG_LIMIT_EN:  limit_en_r <= cfg_data[0];
        knnsi_pkg::CFG_RADIUS2:   radius2_r  <= cfg_data[knnsi_pkg::RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective k: zero acts as one, values above the list depth saturate
  assign knb_w = KW'(knb_r);

  always_comb begin
    if (knb_w == '0) begin
      keff = CNTW'(1);
    end else if (knb_w > KMAX_W) begin
      keff = CNTW'(K_MAX);
    end else begin
      keff = CNTW'(knb_w);
    end
  end

  knnsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  knnsi_dpath #(
    .K_MAX      (K_MAX),
    .COORD_BITS (COORD_BITS),
    .CNTW       (CNTW)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cand_x       (in_cand_x),
    .in_cand_y       (in_cand_y),
    .in_cand_z       (in_cand_z),
    .in_cand_mass    (in_cand_mass),
    .in_cand_index   (in_cand_index),
    .query_x         (query_x_r),
    .query_y         (query_y_r),
    .query_z         (query_z_r),
    .keff            (keff),
    .limit_en        (limit_en_r),
    .radius2         (radius2_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_accepted    (out_accepted),
    .out_count       (out_count),
    .out_kth_dist2   (out_kth_dist2),
    .out_rank        (out_rank),
    .out_entry_index (out_entry_index),
    .out_entry_dist2 (out_entry_dist2),
    .out_entry_mass  (out_entry_mass),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

>>> design/knnsi_ctrl.sv
// Sequencing state machine of the sorted insertion core.
`default_nettype none
`include "assert_macros.svh"

module knnsi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_action,
  output logic                  in_stall,
  output knnsi_pkg::cmd_t       cmd,
  input  wire knnsi_pkg::sts_t  sts
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SQ     = 10'b00_0000_0010,
    S_SUM    = 10'b00_0000_0100,
    S_CHECK  = 10'b00_0000_1000,
    S_DECIDE = 10'b00_0001_0000,
    S_SHIFT  = 10'b00_0010_0000,
    S_STAT   = 10'b00_0100_0000,
    S_DKTH   = 10'b00_1000_0000,
    S_DFIRST = 10'b01_0000_0000,
    S_DOUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a new item only when nothing is in flight
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == knnsi_pkg::ACT_DRAIN) begin
            state_nxt = S_DKTH;
          end else begin
            cmd.take  = 1'b1;
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.clamp = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.ok ? S_SHIFT : S_STAT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.stop) begin
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.stat_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DKTH: begin
        cmd.drain_start = 1'b1;
        state_nxt       = S_DFIRST;
      end
      S_DFIRST: begin
        cmd.drain_kth = 1'b1;
        state_nxt     = S_DOUT;
      end
      S_DOUT: begin
        if (sts.out_free) begin
          cmd.drain_load = 1'b1;
          if (sts.drain_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `KNNSI_ASSERT(a_load_needs_room, clk, rst_n, (cmd.stat_load || cmd.drain_load) |-> sts.out_free)
  `KNNSI_ASSERT(a_transfer_leaves_idle, clk, rst_n, ((state_r == S_IDLE) && in_valid) |=> (state_r != S_IDLE))
  `KNNSI_ASSERT(a_drain_ends_idle, clk, rst_n, (cmd.drain_load && sts.drain_last) |=> (state_r == S_IDLE))

endmodule

`default_nettype wire

>>> design/knnsi_dpath.sv
// Distance arithmetic, sorted list memory and output register of the sorted insertion core.
`default_nettype none
`include "assert_macros.svh"

module knnsi_dpath #(
  parameter int K_MAX      = 64,
  parameter int COORD_BITS = 24,
  parameter int CNTW       = 7
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire knnsi_pkg::cmd_t                        cmd,
  output knnsi_pkg::sts_t                             sts,
  // candidate payload
  input  wire logic [COORD_BITS-1:0]                  in_cand_x,
  input  wire logic [COORD_BITS-1:0]                  in_cand_y,
  input  wire logic [COORD_BITS-1:0]                  in_cand_z,
  input  wire logic [knnsi_pkg::MASS_W-1:0]           in_cand_mass,
  input  wire logic [knnsi_pkg::INDEX_W-1:0]          in_cand_index,
  // configuration
  input  wire logic [COORD_BITS-1:0]                  query_x,
  input  wire logic [COORD_BITS-1:0]                  query_y,
  input  wire logic [COORD_BITS-1:0]                  query_z,
  input  wire logic [CNTW-1:0]                        keff,
  input  wire logic                                   limit_en,
  input  wire logic [knnsi_pkg::RADIUS_W-1:0]         radius2,
  // result channel
  input  wire logic                                   out_stall,
  output logic                                        out_valid,
  output logic                                        out_kind,
  output logic                                        out_accepted,
  output logic [knnsi_pkg::COUNT_W-1:0]               out_count,
  output logic [knnsi_pkg::DIST_OUT_W-1:0]            out_kth_dist2,
  output logic [knnsi_pkg::RANK_W-1:0]                out_rank,
  output logic [knnsi_pkg::INDEX_W-1:0]               out_entry_index,
  output logic [knnsi_pkg::DIST_OUT_W-1:0]            out_entry_dist2,
  output logic [knnsi_pkg::MASS_W-1:0]                out_entry_mass,
  output logic                                        out_last
);

  localparam int AW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int SQW   = 2 * COORD_BITS;
  localparam int DW    = SQW + 2;
  localparam int CMPW  = (DW > knnsi_pkg::RADIUS_W) ? DW : knnsi_pkg::RADIUS_W;
  localparam int MIW   = knnsi_pkg::MASS_W + knnsi_pkg::INDEX_W;
  localparam int EW    = DW + MIW;
  localparam logic [CNTW-1:0] FILL_MAX = CNTW'(K_MAX);

  // Candidate pipeline
  logic [COORD_BITS-1:0]           dx_r, dy_r, dz_r;
  logic [SQW-1:0]                  sqx_r, sqy_r, sqz_r;
  logic [DW-1:0]                   dist_r;
  logic [knnsi_pkg::MASS_W-1:0]    mass_r;
  logic [knnsi_pkg::INDEX_W-1:0]   index_r;

  // List control
  logic [CNTW-1:0] fill_r;
  logic [CNTW-1:0] i_r;
  logic [AW-1:0]   p_r;
  logic [AW-1:0]   top_r;
  logic [DW-1:0]   kth_r;
  logic            acc_r;

  // List memory
  logic [EW-1:0]   list_mem_r [K_MAX];
  logic [EW-1:0]   rd_data_r;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [EW-1:0]   wr_data;

  // Output register
  logic                                out_valid_r;
  logic                                out_kind_r;
  logic                                out_accepted_r;
  logic [knnsi_pkg::COUNT_W-1:0]       out_count_r;
  logic [knnsi_pkg::DIST_OUT_W-1:0]    out_kth_dist2_r;
  logic [knnsi_pkg::RANK_W-1:0]        out_rank_r;
  logic [knnsi_pkg::INDEX_W-1:0]       out_entry_index_r;
  logic [knnsi_pkg::DIST_OUT_W-1:0]    out_entry_dist2_r;
  logic [knnsi_pkg::MASS_W-1:0]        out_entry_mass_r;
  logic                                out_last_r;

  // Combinational helpers
  logic [COORD_BITS-1:0]           adx, ady, adz;
  logic [DW-1:0]                   rd_dist;
  logic [knnsi_pkg::MASS_W-1:0]    rd_mass;
  logic [knnsi_pkg::INDEX_W-1:0]   rd_index;
  logic [CNTW-1:0]                 fill_c, fill_c_m1, fill_m1, keff_m1, i_inc, fill_inc;
  logic [AW-1:0]                   top_c, top_m1, p_m1, p_m2;
  logic                            fill_lt_k, fill_zero, lim_ok, ok, stop, drain_last;
  logic                            out_free;

  // Absolute axis differences
  assign adx = (in_cand_x >= query_x) ? (in_cand_x - query_x) : (query_x - in_cand_x);
  assign ady = (in_cand_y >= query_y) ? (in_cand_y - query_y) : (query_y - in_cand_y);
  assign adz = (in_cand_z >= query_z) ? (in_cand_z - query_z) : (query_z - in_cand_z);

  // Unpack the registered read word
  assign rd_dist  = rd_data_r[EW-1 -: DW];
  assign rd_mass  = rd_data_r[MIW-1 -: knnsi_pkg::MASS_W];
  assign rd_index = rd_data_r[knnsi_pkg::INDEX_W-1:0];

  // Fill and pointer arithmetic
  assign fill_c    = (fill_r > keff) ? keff : fill_r;
  assign fill_c_m1 = fill_c - 1'b1;
  assign fill_m1   = fill_r - 1'b1;
  assign fill_inc  = fill_r + 1'b1;
  assign keff_m1   = keff - 1'b1;
  assign i_inc     = i_r + 1'b1;
  assign fill_lt_k = (fill_r < keff);
  assign fill_zero = (fill_r == '0);
  assign top_c     = fill_lt_k ? fill_r[AW-1:0] : keff_m1[AW-1:0];
  assign top_m1    = top_c - 1'b1;
  assign p_m1      = p_r - 1'b1;
  assign p_m2      = p_m1 - 1'b1;

  // Acceptance: radius test, then room or nearer than the k-th entry
  assign lim_ok     = !limit_en || (CMPW'(dist_r) < CMPW'(radius2));
  assign ok         = lim_ok && (fill_lt_k || (dist_r < rd_dist));
  // Stop once the entry below is not farther (equal entries stay in front)
  assign stop       = (p_r == '0) || (rd_dist <= dist_r);
  assign drain_last = fill_zero || (i_inc == fill_r);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    sts            = '0;
    sts.ok         = ok;
    sts.stop       = stop;
    sts.drain_last = drain_last;
    sts.out_free   = out_free;
  end

  // Read port address selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.clamp) begin
      rd_en   = (fill_c != '0);
      rd_addr = fill_c_m1[AW-1:0];
    end else if (cmd.decide) begin
      rd_en   = ok && !fill_lt_k && (top_c != '0);
      rd_addr = top_m1;
    end else if (cmd.shift) begin
      rd_en   = !stop && (p_r > AW'(1));
      rd_addr = p_m2;
    end else if (cmd.drain_start) begin
      rd_en   = !fill_zero;
      rd_addr = fill_m1[AW-1:0];
    end else if (cmd.drain_kth) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.drain_load) begin
      rd_en   = !drain_last;
      rd_addr = i_inc[AW-1:0];
    end
  end

  // Write port: move the farther entry up or place the candidate
  assign wr_en   = cmd.shift;
  assign wr_addr = p_r;
  assign wr_data = stop ? {dist_r, mass_r, index_r} : rd_data_r;

  // List memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      list_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= list_mem_r[rd_addr];
    end
  end

  // Distance pipeline
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      dx_r    <= adx;
      dy_r    <= ady;
      dz_r    <= adz;
      mass_r  <= in_cand_mass;
      index_r <= in_cand_index;
    end
    if (cmd.square) begin
      sqx_r <= {{COORD_BITS{1'b0}}, dx_r} * {{COORD_BITS{1'b0}}, dx_r};
      sqy_r <= {{COORD_BITS{1'b0}}, dy_r} * {{COORD_BITS{1'b0}}, dy_r};
      sqz_r <= {{COORD_BITS{1'b0}}, dz_r} * {{COORD_BITS{1'b0}}, dz_r};
    end
    if (cmd.sum) begin
      dist_r <= DW'(sqx_r) + DW'(sqy_r) + DW'(sqz_r);
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.clamp) begin
      fill_r <= fill_c;
    end else if (cmd.shift && stop && fill_lt_k) begin
      fill_r <= fill_inc;
    end else if (cmd.drain_load && drain_last) begin
      fill_r <= '0;
    end
  end

  // Insert pointer, k-th distance, acceptance flag and drain counter
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      acc_r <= ok;
      kth_r <= fill_zero ? '0 : rd_dist;
      p_r   <= top_c;
      top_r <= top_c;
    end
    if (cmd.shift) begin
      if (!stop) begin
        p_r <= p_m1;
      end
      // the write into the top slot sets the new last entry
      if (p_r == top_r) begin
        kth_r <= wr_data[EW-1 -: DW];
      end
    end
    if (cmd.drain_start) begin
      i_r <= '0;
    end
    if (cmd.drain_kth) begin
      kth_r <= fill_zero ? '0 : rd_dist;
    end
    if (cmd.drain_load) begin
      i_r <= i_inc;
    end
  end

  // Output valid: set on load, clear on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.stat_load || cmd.drain_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.stat_load) begin
      out_kind_r        <= knnsi_pkg::KIND_STATUS;
      out_accepted_r    <= acc_r;
      out_count_r       <= knnsi_pkg::COUNT_W'(fill_r);
      out_kth_dist2_r   <= knnsi_pkg::DIST_OUT_W'(kth_r);
      out_rank_r        <= '0;
      out_entry_index_r <= '0;
      out_entry_dist2_r <= '0;
      out_entry_mass_r  <= '0;
      out_last_r        <= 1'b1;
    end else if (cmd.drain_load) begin
      out_kind_r     <= knnsi_pkg::KIND_ENTRY;
      out_accepted_r <= 1'b0;
      out_last_r     <= drain_last;
      if (fill_zero) begin
        // empty list: single marker item
        out_count_r       <= '0;
        out_kth_dist2_r   <= '0;
        out_rank_r        <= '0;
        out_entry_index_r <= '0;
        out_entry_dist2_r <= '0;
        out_entry_mass_r  <= '0;
      end else begin
        out_count_r       <= knnsi_pkg::COUNT_W'(fill_r);
        out_kth_dist2_r   <= knnsi_pkg::DIST_OUT_W'(kth_r);
        out_rank_r        <= knnsi_pkg::RANK_W'(i_r);
        out_entry_index_r <= rd_index;
        out_entry_dist2_r <= knnsi_pkg::DIST_OUT_W'(rd_dist);
        out_entry_mass_r  <= rd_mass;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_accepted    = out_accepted_r;
  assign out_count       = out_count_r;
  assign out_kth_dist2   = out_kth_dist2_r;
  assign out_rank        = out_rank_r;
  assign out_entry_index = out_entry_index_r;
  assign out_entry_dist2 = out_entry_dist2_r;
  assign out_entry_mass  = out_entry_mass_r;
  assign out_last        = out_last_r;

  `KNNSI_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FILL_MAX)
  `KNNSI_ASSERT(a_shift_below_top, clk, rst_n, cmd.shift |-> (p_r <= top_r))
  `KNNSI_ASSERT(a_drain_clears, clk, rst_n, (cmd.drain_load && drain_last) |=> (fill_r == '0))

endmodule

`default_nettype wire
